// File: rtl/max_pool_downscaler_assert.svh
// ----------------------------------------------------------------------------
// max_pool_downscaler_assert.svh
// Assertion macros shared by the checker of the max-pool downscaler.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_DOWNSCALER_ASSERT_SVH
`define MAX_POOL_DOWNSCALER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define MPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define MPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared constants and types of the max-pool downscaler.
// ----------------------------------------------------------------------------
package mpd_pkg;

	// default buffer depth and sample precision
	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int FIELD_W   = 16;
	localparam int DIM_W     = 13;
	localparam int ROW_W     = 12;
	localparam int CFG_IDX_W = 2;

	// input height is limited to this many rows
	localparam int HEIGHT_LIMIT = 4096;

	// register reset values
	localparam logic [DIM_W-1:0] IN_WIDTH_RST   = 13'd1920;
	localparam logic [DIM_W-1:0] IN_HEIGHT_RST  = 13'd1080;
	localparam logic [DIM_W-1:0] OUT_WIDTH_RST  = 13'd1920;
	localparam logic [DIM_W-1:0] OUT_HEIGHT_RST = 13'd1080;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_WIDTH   = 2'd0,
		REG_IN_HEIGHT  = 2'd1,
		REG_OUT_WIDTH  = 2'd2,
		REG_OUT_HEIGHT = 2'd3
	} cfg_reg_t;

	// divider status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/mpd_ram.sv
// ----------------------------------------------------------------------------
// mpd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/mpd_div.sv
// ----------------------------------------------------------------------------
// mpd_div
// Restoring divider, one quotient bit per cycle; holds its results.
// ----------------------------------------------------------------------------
module mpd_div #(
	parameter int W = mpd_pkg::DIM_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [W-1:0]      dividend,
	input  logic [W-1:0]      divisor,
	output mpd_pkg::div_stat_t stat,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [W-1:0]     part_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       fits;

	// one trial subtraction per step
	always_comb begin
		trial = {part_q, quo_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			part_q <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
		end else if (cnt_q != '0) begin
			part_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q  <= {quo_q[W-2:0], fits};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quot      = quo_q;
	assign rem       = part_q;

endmodule

// File: rtl/max_pool_downscaler.sv
// ----------------------------------------------------------------------------
// max_pool_downscaler
// Max-pooling downscaler for one plane of depth samples in raster order.
// ----------------------------------------------------------------------------
// The block takes one sample per clock when not stalled and gives one output
// pixel whenever a sample completes its pooling block. Running maxima of the
// block rows seen so far live in a row buffer RAM indexed by output column;
// each sample reads its entry when it is taken, and a sample that ends its
// column block writes the merged maximum back in the next cycle, with a
// bypass for back-to-back hits on the same entry. Block ends advance by a
// quotient and remainder of input over output size; after reset and after
// every register write, two bit-serial dividers work these out while the
// input is stalled. A two-entry output queue keeps the input moving while a
// result waits to be taken. Any register write restarts the frame.
// ----------------------------------------------------------------------------
module max_pool_downscaler #(
	parameter int MAX_WIDTH   = mpd_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = mpd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpd_pkg::DIM_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mpd_pkg::FIELD_W-1:0]     sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mpd_pkg::FIELD_W-1:0]     max_value,
	output logic                            end_of_row,
	output logic                            end_of_frame
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int DW = mpd_pkg::DIM_W;
	localparam int RW = mpd_pkg::ROW_W;
	localparam int CW = ((AW > DW) ? AW : DW) + 1;
	localparam int SB = SAMPLE_BITS;

	// configuration registers
	logic [DW-1:0] in_width_q, in_height_q, out_width_q, out_height_q;
	logic          start_q;

	// effective sizes
	logic [DW-1:0] in_w_nz, in_h_nz, out_w_nz, out_h_nz;
	logic [DW-1:0] iw, ih, ow, oh;

	// divider results
	mpd_pkg::div_stat_t col_stat, row_stat;
	logic [DW-1:0] col_q_step, col_r_step, row_q_step, row_r_step;
	logic          div_hold;

	// frame position
	logic [AW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [DW-1:0] col_bnd_q, col_rem_q, row_bnd_q, row_rem_q;
	logic          first_row_q;
	logic [SB-1:0] cur_max_q;

	// accept-side decode
	logic          accept;
	logic [SB-1:0] s_val, cm;
	logic          col_end, row_wrap, frame_wrap, last_row, eor, eof;
	logic [DW:0]   col_sum, row_sum;
	logic          col_carry, row_carry;
	logic [DW-1:0] col_bnd_nx, col_rem_nx, row_bnd_nx, row_rem_nx;

	// read-modify-write stage
	logic          s1_valid;
	logic [AW-1:0] s1_addr;
	logic [SB-1:0] s1_cm;
	logic          s1_col_end, s1_last_row, s1_first_row, s1_eor, s1_eof;
	logic [SB-1:0] rdata, prev, merged;
	logic          wr_en, push;
	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [SB-1:0] fwd_data_q;

	// output queue
	logic [1:0]    count_q, occ_nx;
	logic          pop;
	logic [SB-1:0] head_val_q, skid_val_q;
	logic          head_eor_q, head_eof_q, skid_eor_q, skid_eof_q;

	// register writes; every write restarts the frame and the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= mpd_pkg::IN_WIDTH_RST;
			in_height_q  <= mpd_pkg::IN_HEIGHT_RST;
			out_width_q  <= mpd_pkg::OUT_WIDTH_RST;
			out_height_q <= mpd_pkg::OUT_HEIGHT_RST;
			start_q      <= 1'b1;
		end else begin
			start_q <= cfg_we;
			if (cfg_we) begin
				unique case (mpd_pkg::cfg_reg_t'(cfg_index))
					mpd_pkg::REG_IN_WIDTH:   in_width_q   <= cfg_data;
					mpd_pkg::REG_IN_HEIGHT:  in_height_q  <= cfg_data;
					mpd_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data;
					mpd_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data;
				endcase
			end
		end
	end

	// zero sizes count as one, input width clamped to the buffer, input height to the height limit, output to the input
	always_comb begin
		in_w_nz  = (in_width_q == '0) ? DW'(1) : in_width_q;
		in_h_nz  = (in_height_q == '0) ? DW'(1) : in_height_q;
		out_w_nz = (out_width_q == '0) ? DW'(1) : out_width_q;
		out_h_nz = (out_height_q == '0) ? DW'(1) : out_height_q;
		iw = (CW'(in_w_nz) > CW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : in_w_nz;
		ih = (CW'(in_h_nz) > CW'(mpd_pkg::HEIGHT_LIMIT)) ?
			DW'(mpd_pkg::HEIGHT_LIMIT) : in_h_nz;
		ow = (out_w_nz > iw) ? iw : out_w_nz;
		oh = (out_h_nz > ih) ? ih : out_h_nz;
	end

	// block step quotient and remainder for columns and rows
	mpd_div #(.W(DW)) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (iw),
		.divisor  (ow),
		.stat     (col_stat),
		.quot     (col_q_step),
		.rem      (col_r_step)
	);

	mpd_div #(.W(DW)) u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (ih),
		.divisor  (oh),
		.stat     (row_stat),
		.quot     (row_q_step),
		.rem      (row_r_step)
	);

	assign div_hold = start_q || col_stat.busy || col_stat.done ||
		row_stat.busy || row_stat.done;

	// input flow control: held while the dividers work, else room for what is in flight plus one more
	always_comb begin
		pop      = (count_q != 2'd0) && !out_stall;
		occ_nx   = count_q + 2'(push) - 2'(pop);
		in_stall = div_hold || (occ_nx > 2'd1);
		accept   = in_valid && !in_stall;
	end

	// position decode for the incoming sample
	always_comb begin
		s_val      = sample[SB-1:0];
		cm         = (s_val > cur_max_q) ? s_val : cur_max_q;
		col_end    = (CW'(in_col_q) + CW'(1)) >= CW'(col_bnd_q);
		row_wrap   = (CW'(in_col_q) + CW'(1)) >= CW'(iw);
		last_row   = ({1'b0, in_row_q} + DW'(1)) >= row_bnd_q;
		frame_wrap = row_wrap && (({1'b0, in_row_q} + DW'(1)) >= ih);
		eor        = (CW'(out_col_q) + CW'(1)) >= CW'(ow);
		eof        = eor && (({1'b0, out_row_q} + DW'(1)) >= oh);

		col_sum    = {1'b0, col_rem_q} + {1'b0, col_r_step};
		col_carry  = col_sum >= {1'b0, ow};
		col_rem_nx = col_carry ? DW'(col_sum - {1'b0, ow}) : col_sum[DW-1:0];
		col_bnd_nx = col_bnd_q + col_q_step + DW'(col_carry);

		row_sum    = {1'b0, row_rem_q} + {1'b0, row_r_step};
		row_carry  = row_sum >= {1'b0, oh};
		row_rem_nx = row_carry ? DW'(row_sum - {1'b0, oh}) : row_sum[DW-1:0];
		row_bnd_nx = row_bnd_q + row_q_step + DW'(row_carry);
	end

	// frame position and block boundaries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			out_col_q   <= '0;
			in_row_q    <= '0;
			out_row_q   <= '0;
			col_bnd_q   <= DW'(1);
			col_rem_q   <= '0;
			row_bnd_q   <= DW'(1);
			row_rem_q   <= '0;
			first_row_q <= 1'b1;
			cur_max_q   <= '0;
		end else if (cfg_we) begin
			in_col_q    <= '0;
			out_col_q   <= '0;
			in_row_q    <= '0;
			out_row_q   <= '0;
			first_row_q <= 1'b1;
			cur_max_q   <= '0;
		end else if (col_stat.done) begin
			col_bnd_q <= col_q_step;
			col_rem_q <= col_r_step;
			row_bnd_q <= row_q_step;
			row_rem_q <= row_r_step;
		end else if (accept) begin
			cur_max_q <= col_end ? '0 : cm;
			if (row_wrap) begin
				in_col_q  <= '0;
				out_col_q <= '0;
				col_bnd_q <= col_q_step;
				col_rem_q <= col_r_step;
				if (frame_wrap) begin
					in_row_q    <= '0;
					out_row_q   <= '0;
					row_bnd_q   <= row_q_step;
					row_rem_q   <= row_r_step;
					first_row_q <= 1'b1;
				end else if (last_row) begin
					in_row_q    <= in_row_q + RW'(1);
					out_row_q   <= out_row_q + RW'(1);
					row_bnd_q   <= row_bnd_nx;
					row_rem_q   <= row_rem_nx;
					first_row_q <= 1'b1;
				end else begin
					in_row_q    <= in_row_q + RW'(1);
					first_row_q <= 1'b0;
				end
			end else begin
				in_col_q <= in_col_q + AW'(1);
				if (col_end) begin
					out_col_q <= out_col_q + AW'(1);
					col_bnd_q <= col_bnd_nx;
					col_rem_q <= col_rem_nx;
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_addr      <= out_col_q;
			s1_cm        <= cm;
			s1_col_end   <= col_end;
			s1_last_row  <= last_row;
			s1_first_row <= first_row_q;
			s1_eor       <= eor;
			s1_eof       <= eof;
		end
	end

	// row buffer of running column maxima
	mpd_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_row_buf (
		.clk   (clk),
		.we    (wr_en),
		.waddr (s1_addr),
		.wdata (merged),
		.re    (accept),
		.raddr (out_col_q),
		.rdata (rdata)
	);

	// merge with earlier block rows, bypassing the write of the previous cycle
	always_comb begin
		prev   = (fwd_valid_q && (fwd_addr_q == s1_addr)) ? fwd_data_q : rdata;
		merged = (!s1_first_row && (prev > s1_cm)) ? prev : s1_cm;
		wr_en  = s1_valid && s1_col_end;
		push   = wr_en && s1_last_row;
	end

	// last write for the bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= s1_addr;
			fwd_data_q <= merged;
		end
	end

	// output queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= occ_nx;
		end
	end

	// output queue payload: head is shown, skid takes a transaction behind it
	always_ff @(posedge clk) begin
		if (pop || (count_q == 2'd0)) begin
			if (count_q == 2'd2) begin
				head_val_q <= skid_val_q;
				head_eor_q <= skid_eor_q;
				head_eof_q <= skid_eof_q;
			end else begin
				head_val_q <= merged;
				head_eor_q <= s1_eor;
				head_eof_q <= s1_eof;
			end
		end
		if (push && (((count_q == 2'd1) && !pop) || ((count_q == 2'd2) && pop))) begin
			skid_val_q <= merged;
			skid_eor_q <= s1_eor;
			skid_eof_q <= s1_eof;
		end
	end

	assign out_valid    = (count_q != 2'd0);
	assign max_value    = mpd_pkg::FIELD_W'(head_val_q);
	assign end_of_row   = head_eor_q;
	assign end_of_frame = head_eof_q;

endmodule

// File: rtl/mpd_chk.sv
// ----------------------------------------------------------------------------
// mpd_chk
// Port-level checks of the max-pool downscaler, bound to its top level.
// ----------------------------------------------------------------------------
`include "max_pool_downscaler_assert.svh"

module mpd_chk #(
	parameter int SAMPLE_BITS = mpd_pkg::SAMPLE_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_we,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [mpd_pkg::FIELD_W-1:0] sample,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [mpd_pkg::FIELD_W-1:0] max_value,
	input logic                        end_of_row,
	input logic                        end_of_frame
);

	// whole result payload in one word
	logic [mpd_pkg::FIELD_W+1:0] out_word;

	assign out_word = {max_value, end_of_row, end_of_frame};

	// a stalled result transaction holds
	`MPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result changed while stalled")

	// a stalled input transaction holds
	`MPD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(sample), "input changed while stalled")

	// last pixel of the frame is also last of its row
	`MPD_ASSERT_NOW(a_eof_eor, out_valid && end_of_frame, end_of_row, "end_of_frame without end_of_row")

	// a register write holds off input while the block steps are worked out
	`MPD_ASSERT_NEXT(a_cfg_hold, cfg_we, in_stall, "input taken right after a register write")

	// results never exceed the sample precision
	`MPD_ASSERT_NOW(a_range, out_valid, (max_value >> SAMPLE_BITS) == '0, "result wider than sample")

endmodule

bind max_pool_downscaler mpd_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_mpd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.sample       (sample),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.max_value    (max_value),
	.end_of_row   (end_of_row),
	.end_of_frame (end_of_frame)
);
